// ===== sv/cmn_pkg.sv =====
// Package for the complex magnitude normalizer.
// Holds the shared constants and the controller/datapath command and status types.
// No dependencies.
package cmn_pkg;

  // Default width of the real and imaginary sample parts.
  localparam int unsigned SAMPLE_BITS = 16;

  // Width of the pixel result.
  localparam int unsigned PIXEL_BITS = 8;

  // Quotient steps of the divider: eight pixel bits plus one saturation bit.
  localparam int unsigned DIV_STEPS = PIXEL_BITS + 1;

  // Largest pixel value, used on saturation.
  localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = '1;

  // Input mode codes.
  localparam logic MODE_SCAN    = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture an accepted item
    logic sq_a;       // square the real magnitude
    logic sq_b;       // keep the first square, square the imaginary magnitude
    logic sqrt_init;  // add the squares and load the root unit
    logic sqrt_step;  // one root bit
    logic peak_upd;   // fold the magnitude into the peak
    logic div_init;   // load numerator and divisor
    logic div_step;   // one quotient bit
    logic out_load;   // write the pixel register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;       // mode of the item at work
  } status_t;

endpackage

// ===== sv/cmn_ifs.sv =====
// Handshake interfaces of the complex magnitude normalizer: sample input and pixel output.
// Depends on cmn_pkg.
interface cmn_in_if #(
  parameter int unsigned SAMPLE_BITS = cmn_pkg::SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] re;
  logic signed [SAMPLE_BITS-1:0] im;

  modport source (output valid, output mode, output re, output im, input ready);
  modport sink   (input valid, input mode, input re, input im, output ready);
endinterface

interface cmn_out_if ();
  logic                              valid;
  logic                              ready;
  logic [cmn_pkg::PIXEL_BITS-1:0]    pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== sv/cmn_datapath.sv =====
// Datapath of the complex magnitude normalizer: squares, bit-serial root, peak, divider.
// Depends on cmn_pkg; driven by cmn_ctrl through cmn_pkg::cmd_t.
module cmn_datapath #(
  parameter int unsigned SAMPLE_BITS = cmn_pkg::SAMPLE_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               mode_i,
  input  logic signed [SAMPLE_BITS-1:0]      re_i,
  input  logic signed [SAMPLE_BITS-1:0]      im_i,
  input  cmn_pkg::cmd_t                      cmd_i,
  output cmn_pkg::status_t                   status_o,
  output logic [cmn_pkg::PIXEL_BITS-1:0]     pixel_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned PW = 2 * SB;                 // one square
  localparam int unsigned RW = SB + 1;                 // magnitude
  localparam int unsigned NW = RW + cmn_pkg::PIXEL_BITS; // scaled magnitude
  localparam int unsigned PB = cmn_pkg::PIXEL_BITS;

  logic [SB-1:0]     a_q, b_q;
  logic              mode_q;
  logic [PW-1:0]     prod_q, sum_q;
  logic [2*RW-1:0]   rad_q;
  logic [RW+1:0]     rem_q;
  logic [RW-1:0]     root_q;
  logic [RW-1:0]     peak_q;
  logic              conv_q;
  logic [NW-1:0]     num_q, dsh_q;
  logic [PB:0]       quo_q;
  logic [PB-1:0]     pixel_q;

  logic [SB-1:0]     re_u, im_u, abs_re, abs_im;
  logic [RW+1:0]     rem_sh, trial;
  logic              root_ge;
  logic [RW-1:0]     peak_base, divisor;
  logic              div_ge;

  // Absolute values; the most negative sample fits as unsigned.
  assign re_u   = re_i;
  assign im_u   = im_i;
  assign abs_re = re_i[SB-1] ? (~re_u + 1'b1) : re_u;
  assign abs_im = im_i[SB-1] ? (~im_u + 1'b1) : im_u;

  // Restoring square root: bring down two radicand bits, try root*4+1.
  assign rem_sh  = {rem_q[RW-1:0], rad_q[2*RW-1 -: 2]};
  assign trial   = {root_q, 2'b01};
  assign root_ge = rem_sh >= trial;

  // A new scan pass starts the peak from zero; a zero peak divides as one.
  assign peak_base = conv_q ? '0 : peak_q;
  assign divisor   = (peak_q == '0) ? RW'(1) : peak_q;

  // Restoring division step against the shifted divisor.
  assign div_ge = num_q >= dsh_q;

  // Sample capture and the shared multiplier.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= abs_re;
      b_q    <= abs_im;
      mode_q <= mode_i;
    end
    if (cmd_i.sq_a) begin
      prod_q <= a_q * a_q;
    end
    if (cmd_i.sq_b) begin
      sum_q  <= prod_q;
      prod_q <= b_q * b_q;
    end
  end

  // Bit-serial root unit, one root bit a cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rad_q  <= {1'b0, {1'b0, sum_q} + {1'b0, prod_q}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[2*RW-3:0], 2'b00};
      rem_q  <= root_ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RW-2:0], root_ge};
    end
  end

  // Peak tracking and the pass flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      conv_q <= 1'b0;
    end else if (cmd_i.peak_upd) begin
      peak_q <= (root_q > peak_base) ? root_q : peak_base;
      conv_q <= 1'b0;
    end else if (cmd_i.div_init) begin
      conv_q <= 1'b1;
    end
  end

  // Divider: numerator is 255 times the magnitude, nine quotient bits.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      num_q <= {root_q, {PB{1'b0}}} - {{PB{1'b0}}, root_q};
      dsh_q <= {divisor, {PB{1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= div_ge ? (num_q - dsh_q) : num_q;
      dsh_q <= {1'b0, dsh_q[NW-1:1]};
      quo_q <= {quo_q[PB-1:0], div_ge};
    end
  end

  // Pixel register; a quotient of 256 or more saturates.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_q <= quo_q[PB] ? cmn_pkg::PIXEL_MAX : quo_q[PB-1:0];
    end
  end

  assign pixel_o       = pixel_q;
  assign status_o.mode = mode_q;

endmodule

// ===== sv/cmn_ctrl.sv =====
// Controller of the complex magnitude normalizer: sequences one item through the datapath.
// Depends on cmn_pkg; commands cmn_datapath and owns the output valid flag.
module cmn_ctrl #(
  parameter int unsigned SAMPLE_BITS = cmn_pkg::SAMPLE_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  cmn_pkg::status_t status_i,
  output cmn_pkg::cmd_t    cmd_o
);

  localparam int unsigned RW = SAMPLE_BITS + 1;
  localparam int unsigned CW = $clog2(RW + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQ_A  = 9'b000000010,
    S_SQ_B  = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_SQRT  = 9'b000010000,
    S_PEAK  = 9'b000100000,
    S_DLOAD = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;
  logic          in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Next state, step counter and commands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SQ_A;
        end
      end
      S_SQ_A: begin
        cmd_o.sq_a = 1'b1;
        state_d    = S_SQ_B;
      end
      S_SQ_B: begin
        cmd_o.sq_b = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CW'(RW - 1)) begin
          state_d = (status_i.mode == cmn_pkg::MODE_CONVERT) ? S_DLOAD : S_PEAK;
        end
      end
      S_PEAK: begin
        cmd_o.peak_upd = 1'b1;
        state_d        = S_IDLE;
      end
      S_DLOAD: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CW'(cmn_pkg::DIV_STEPS - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output item stays valid until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pixel register loaded over an untaken item");

  // A loaded result is offered in the next cycle.
  a_out_offered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("loaded pixel not offered");

  // An accepted item starts the squaring sequence.
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_SQ_A))
    else $error("accepted item did not start");

  // The step counter stays within the root length.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |-> (cnt_q < CW'(RW)))
    else $error("root step counter out of range");

endmodule

// ===== sv/complex_magnitude_normalizer_core.sv =====
// Complex magnitude normalizer: one item at a time, sequenced by a controller. A scan item
// (mode 0) passes through the two squares, the root and the peak update and gives no result;
// a convert item (mode 1) passes through the squares, the root and the divider, has its pixel
// loaded once any earlier pixel has been taken, and frees the input in the cycle after the load.
// The sequence uses the bit-serial square root, one of SAMPLE_BITS+1 root bits a cycle, the
// nine-step restoring divider, and the shared multiplier used twice per item.
// A new item is accepted while a finished pixel still waits in the output register.
// Depends on cmn_pkg, cmn_ifs, cmn_ctrl and cmn_datapath.
module complex_magnitude_normalizer_core #(
  parameter int unsigned SAMPLE_BITS = cmn_pkg::SAMPLE_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmn_in_if.sink     sample_i,
  cmn_out_if.source  pixel_o
);

  cmn_pkg::cmd_t    cmd;
  cmn_pkg::status_t status;

  // Sequencer.
  cmn_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (pixel_o.valid),
    .out_ready_i (pixel_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and item state.
  cmn_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mode_i   (sample_i.mode),
    .re_i     (sample_i.re),
    .im_i     (sample_i.im),
    .cmd_i    (cmd),
    .status_o (status),
    .pixel_o  (pixel_o.pixel)
  );

endmodule

// ===== tb/complex_magnitude_normalizer_checker.sv =====
// Checker for the complex magnitude normalizer: watches the sample and pixel channels,
// predicts every pixel from the accepted samples and compares them in order.
// Depends on cmn_pkg and cmn_ifs.
module complex_magnitude_normalizer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmn_in_if           sample_mon,
  cmn_out_if          pixel_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned scan_count_o,
  output int unsigned pixel_count_o
);

  // Predicted state: running peak and whether a convert pass is under way.
  logic [cmn_pkg::SAMPLE_BITS:0]  peak_mag;
  logic                           convert_pass;
  logic [cmn_pkg::PIXEL_BITS-1:0] pixel_expected_q[$];

  // Floor of the square root of re*re + im*im, built bit by bit from the top.
  function automatic logic [cmn_pkg::SAMPLE_BITS:0] sample_magnitude(
    input logic signed [cmn_pkg::SAMPLE_BITS-1:0] re,
    input logic signed [cmn_pkg::SAMPLE_BITS-1:0] im
  );
    longint          re_abs;
    longint          im_abs;
    longint unsigned power;
    longint unsigned root;
    longint unsigned trial;
    re_abs = re;
    im_abs = im;
    if (re_abs < 0) re_abs = -re_abs;
    if (im_abs < 0) im_abs = -im_abs;
    power = longint'(re_abs * re_abs + im_abs * im_abs);
    root  = 0;
    for (int k = cmn_pkg::SAMPLE_BITS; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= power) root = trial;
    end
    return root[cmn_pkg::SAMPLE_BITS:0];
  endfunction

  // Pixel = floor(255 * magnitude / peak), a zero peak divides as one, saturated at 255.
  function automatic logic [cmn_pkg::PIXEL_BITS-1:0] scaled_pixel(
    input logic [cmn_pkg::SAMPLE_BITS:0] mag,
    input logic [cmn_pkg::SAMPLE_BITS:0] peak
  );
    longint unsigned divisor;
    longint unsigned quotient;
    divisor  = (peak == '0) ? 64'd1 : longint'(peak);
    quotient = (longint'(mag) * longint'(cmn_pkg::PIXEL_MAX)) / divisor;
    if (quotient > longint'(cmn_pkg::PIXEL_MAX)) quotient = longint'(cmn_pkg::PIXEL_MAX);
    return quotient[cmn_pkg::PIXEL_BITS-1:0];
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    fail_count_o++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  initial begin
    fail_count_o = 0;
  end

  // Follow both channels at every edge: compare pixels, then fold in accepted samples.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [cmn_pkg::SAMPLE_BITS:0]  mag;
    logic [cmn_pkg::PIXEL_BITS-1:0] want;
    if (!rst_ni) begin
      peak_mag      = '0;
      convert_pass  = 1'b0;
      pixel_expected_q.delete();
      pending_o     <= 0;
      scan_count_o  <= 0;
      pixel_count_o <= 0;
    end else begin
      if (pixel_mon.valid && pixel_mon.ready) begin
        pixel_count_o <= pixel_count_o + 1;
        if (pixel_expected_q.size() == 0) begin
          report_mismatch($sformatf("pixel %0d arrived with none expected", pixel_mon.pixel));
        end else begin
          want = pixel_expected_q.pop_front();
          if (pixel_mon.pixel !== want) begin
            report_mismatch($sformatf("pixel %0d, expected %0d", pixel_mon.pixel, want));
          end
        end
      end
      if (sample_mon.valid && sample_mon.ready) begin
        mag = sample_magnitude(sample_mon.re, sample_mon.im);
        if (sample_mon.mode == cmn_pkg::MODE_SCAN) begin
          // The first scan item after a convert pass starts a new peak.
          if (convert_pass) begin
            peak_mag     = '0;
            convert_pass = 1'b0;
          end
          if (mag > peak_mag) peak_mag = mag;
          scan_count_o <= scan_count_o + 1;
        end else begin
          convert_pass = 1'b1;
          pixel_expected_q.push_back(scaled_pixel(mag, peak_mag));
        end
      end
      pending_o <= pixel_expected_q.size();
    end
  end

endmodule

// ===== tb/complex_magnitude_normalizer_core_tb.sv =====
// Testbench top for the complex magnitude normalizer: clock, reset, sample stimulus,
// a randomly stalling pixel receiver and the verdict.
// Depends on cmn_pkg, cmn_ifs, the core and complex_magnitude_normalizer_checker.
module complex_magnitude_normalizer_core_tb;

  localparam int unsigned ITEM_TARGET   = 550;
  localparam int unsigned CYCLE_LIMIT   = 250000;
  localparam int unsigned TAIL_CYCLES   = 64;
  localparam int unsigned DRAIN_AT_ITEM = 300;
  // Back-to-back windows with no idling on either side.
  localparam int unsigned BURST_FROM    = 150;
  localparam int unsigned BURST_TO      = 220;
  localparam int unsigned FAST_FROM     = 90;
  localparam int unsigned FAST_TO       = 130;
  // Long receiver stall so that the block fills up and stops taking samples.
  localparam int unsigned HOLD_AT_PIXEL = 40;
  localparam int unsigned LONG_HOLD     = 300;

  // Value ranges for the random sample parts.
  typedef enum int unsigned {SPAN_TINY, SPAN_MID, SPAN_FULL, SPAN_EDGE} span_e;

  logic        clk;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int unsigned items_sent;
  int unsigned fail_count;
  int unsigned pixels_pending;
  int unsigned scan_count;
  int unsigned pixel_count;

  cmn_in_if  sample_if ();
  cmn_out_if pixel_if ();

  complex_magnitude_normalizer_core u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_if),
    .pixel_o  (pixel_if)
  );

  complex_magnitude_normalizer_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .sample_mon    (sample_if),
    .pixel_mon     (pixel_if),
    .fail_count_o  (fail_count),
    .pending_o     (pixels_pending),
    .scan_count_o  (scan_count),
    .pixel_count_o (pixel_count)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // One random sample part from the given range.
  function automatic logic signed [cmn_pkg::SAMPLE_BITS-1:0] draw_part(input span_e span);
    int v;
    case (span)
      SPAN_TINY: v = int'($urandom_range(0, 16)) - 8;
      SPAN_MID:  v = int'($urandom_range(0, 800)) - 400;
      SPAN_FULL: v = int'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = -32767;
          3:       v = 0;
          4:       v = 1;
          default: v = -1;
        endcase
      end
    endcase
    return v[cmn_pkg::SAMPLE_BITS-1:0];
  endfunction

  // Offers one item, waits for it to be taken, then idles for a drawn gap, none in the burst window.
  task automatic offer_sample(
    input logic                                   mode,
    input logic signed [cmn_pkg::SAMPLE_BITS-1:0] re,
    input logic signed [cmn_pkg::SAMPLE_BITS-1:0] im
  );
    int unsigned gap;
    sample_if.valid <= 1'b1;
    sample_if.mode  <= mode;
    sample_if.re    <= re;
    sample_if.im    <= im;
    do @(posedge clk); while (!sample_if.ready);
    items_sent++;
    gap = (items_sent >= BURST_FROM && items_sent < BURST_TO) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering until every predicted pixel has been taken.
  task automatic wait_for_drain();
    sample_if.valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
  endtask

  // Pixel receiver: a drawn wait before each item, one long hold, one fast window.
  initial begin : pixel_receiver
    int unsigned wait_cycles;
    int unsigned taken;
    pixel_if.ready = 1'b0;
    taken = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (taken == HOLD_AT_PIXEL) begin
        wait_cycles = LONG_HOLD;
      end else if (taken >= FAST_FROM && taken < FAST_TO) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 8);
      end
      if (wait_cycles != 0) begin
        pixel_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      pixel_if.ready <= 1'b1;
      do @(posedge clk); while (!pixel_if.valid);
      taken++;
    end
  end

  // Reset, directed items, random passes, then drain and verdict.
  initial begin : sample_sender
    span_e       span;
    int unsigned run_len;
    bit          drained_mid;
    sample_if.valid = 1'b0;
    sample_if.mode  = cmn_pkg::MODE_SCAN;
    sample_if.re    = '0;
    sample_if.im    = '0;
    rst_n           = 1'b0;
    items_sent      = 0;
    drained_mid     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Convert before any scan: the peak is zero and divides as one.
    offer_sample(cmn_pkg::MODE_CONVERT, 16'sd0, 16'sd0);
    offer_sample(cmn_pkg::MODE_CONVERT, 16'sd1, 16'sd0);
    offer_sample(cmn_pkg::MODE_CONVERT, -16'sd32768, -16'sd32768);
    // A new scan pass with only zero samples keeps a zero peak.
    offer_sample(cmn_pkg::MODE_SCAN, 16'sd0, 16'sd0);
    offer_sample(cmn_pkg::MODE_CONVERT, 16'sd0, 16'sd5);
    offer_sample(cmn_pkg::MODE_CONVERT, 16'sd0, 16'sd0);
    // Most negative samples set the largest possible peak; most positive ones stay below it.
    offer_sample(cmn_pkg::MODE_SCAN, -16'sd32768, -16'sd32768);
    offer_sample(cmn_pkg::MODE_SCAN, 16'sd32767, 16'sd32767);
    offer_sample(cmn_pkg::MODE_SCAN, 16'sd0, 16'sd0);
    offer_sample(cmn_pkg::MODE_CONVERT, -16'sd32768, -16'sd32768);
    offer_sample(cmn_pkg::MODE_CONVERT, 16'sd32767, -16'sd32768);
    offer_sample(cmn_pkg::MODE_CONVERT, -16'sd32768, 16'sd0);
    offer_sample(cmn_pkg::MODE_CONVERT, 16'sd1, -16'sd1);
    offer_sample(cmn_pkg::MODE_CONVERT, 16'sd12345, -16'sd6789);
    // Small peak: quotients above 255 saturate, smaller ones scale.
    offer_sample(cmn_pkg::MODE_SCAN, 16'sd3, 16'sd4);
    offer_sample(cmn_pkg::MODE_SCAN, -16'sd1, 16'sd2);
    offer_sample(cmn_pkg::MODE_CONVERT, 16'sd6, 16'sd8);
    offer_sample(cmn_pkg::MODE_CONVERT, 16'sd3, -16'sd4);
    offer_sample(cmn_pkg::MODE_CONVERT, -16'sd1, 16'sd2);
    offer_sample(cmn_pkg::MODE_CONVERT, 16'sd0, -16'sd3);

    // Random scan/convert passes in a shared range, with some loose items mixed in.
    while (items_sent < ITEM_TARGET) begin
      if (!drained_mid && items_sent >= DRAIN_AT_ITEM) begin
        wait_for_drain();
        drained_mid = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        span    = span_e'($urandom_range(0, 3));
        run_len = $urandom_range(1, 10);
        repeat (run_len) offer_sample(cmn_pkg::MODE_SCAN, draw_part(span), draw_part(span));
        run_len = $urandom_range(1, 10);
        repeat (run_len) begin
          offer_sample(cmn_pkg::MODE_CONVERT, draw_part(span), draw_part(span));
        end
      end else begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) begin
          offer_sample($urandom_range(0, 1) ? cmn_pkg::MODE_CONVERT : cmn_pkg::MODE_SCAN,
                       draw_part(span_e'($urandom_range(0, 3))),
                       draw_part(span_e'($urandom_range(0, 3))));
        end
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d scan items and %0d pixels checked, with a long output stall",
             items_sent, scan_count, pixel_count);
    $display("and a full drain mid-run; zero peak, saturation and extreme samples included.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cmn_pkg.sv
sv/cmn_ifs.sv
sv/cmn_datapath.sv
sv/cmn_ctrl.sv
sv/complex_magnitude_normalizer_core.sv
tb/complex_magnitude_normalizer_checker.sv
tb/complex_magnitude_normalizer_core_tb.sv
